@@ sv/bmp_row_pixel_unpacker_unit_defines.svh @@
// Assertion macros shared by the bitmap row unpacker modules.
`ifndef BMP_ROW_PIXEL_UNPACKER_UNIT_DEFINES_SVH
`define BMP_ROW_PIXEL_UNPACKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define BMPRU_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmpru assertion failed");
// Next-cycle implication, disabled during reset.
`define BMPRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmpru assertion failed");
`else
`define BMPRU_ASSERT(label, clk, rst, ante, cons)
`define BMPRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/bmpru_pkg.sv @@
// Types, codes and helpers shared by the bitmap row unpacker modules.
package bmpru_pkg;

   // Default sizing
   localparam int BMPRU_MAX_WIDTH        = 1024;
   localparam int BMPRU_MAX_HEIGHT       = 1024;
   localparam int BMPRU_SCALE_LIMIT      = 33;
   localparam int BMPRU_PALETTE_ENTRIES  = 256;
   localparam int BMPRU_QUEUE_DEPTH      = 4;

   // Input word kinds
   localparam logic [1:0] KIND_PALETTE = 2'd0;
   localparam logic [1:0] KIND_PIXEL   = 2'd1;
   localparam logic [1:0] KIND_START   = 2'd2;

   // Depth codes
   localparam logic [1:0] DEPTH_1BPP  = 2'd0;
   localparam logic [1:0] DEPTH_4BPP  = 2'd1;
   localparam logic [1:0] DEPTH_8BPP  = 2'd2;
   localparam logic [1:0] DEPTH_24BPP = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_DEPTH  = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_DOUBLE = 2'd3;

   // One word of work handed from the front end to the back end
   typedef struct packed {
      logic        is_pal;     // palette write, else pixel byte
      logic [7:0]  pal_index;
      logic [23:0] pal_color;
      logic [15:0] data;       // index byte in [7:0], or ready RGB565 for 24 bpp
      logic [1:0]  depth;
      logic [10:0] col;        // first source column of this byte
      logic [3:0]  cnt;        // source pixels to send, 1..8
      logic [9:0]  row;
      logic        dbl;
      logic        row_end;    // last pixel of this word closes the row
      logic        last_row;
   } job_type;

   function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

@@ sv/bmp_row_pixel_unpacker_unit.sv @@
// Top level of the bitmap row unpacker: front end, work queue and back end.
//
// Input channel req_*: palette words (kind 0), pixel-array bytes (kind 1) and
// start-of-image words (kind 2), valid/ready. Result channel rsp_*: one RGB565
// pixel per word with its output column, source row and end-of-row and
// end-of-image flags, valid/ready. csr_* writes depth, width, height and the
// doubling request; write only while no work is in flight.
//
// The front end takes one input word per cycle while the 4-word queue has room.
// The back end retires a palette word without a result and turns a pixel byte
// into its results one by one, up to 8 (1 bpp) or 16 (1 bpp doubled) per byte,
// so the sequencer in the back end sets the sustained rate. A byte passes
// through a queue slot, the current-word register and the output register.
//
// Reset clears the progress counters and the queue and loads the register
// defaults (24 bpp, 1 x 1, no doubling); palette contents stay unknown until
// loaded. When the receiver stalls, the result holds in the output register,
// the back end holds its pixel byte, and the queue fills and drops req_ready.
module bmp_row_pixel_unpacker_unit
   import bmpru_pkg::*;
#(
   parameter int MAX_WIDTH         = BMPRU_MAX_WIDTH,
   parameter int MAX_HEIGHT        = BMPRU_MAX_HEIGHT,
   parameter int SCALE_WIDTH_LIMIT = BMPRU_SCALE_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_rgb565,
   output logic [10:0] rsp_out_x,
   output logic [9:0]  rsp_src_row,
   output logic        rsp_row_last,
   output logic        rsp_image_last
);

   logic    push, q_full, q_not_empty, pop;
   job_type push_job, head_job;

   bmpru_front #(
      .MAX_WIDTH         (MAX_WIDTH),
      .MAX_HEIGHT        (MAX_HEIGHT),
      .SCALE_WIDTH_LIMIT (SCALE_WIDTH_LIMIT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .req_data_byte     (req_data_byte),
      .q_full            (q_full),
      .push              (push),
      .push_job          (push_job)
   );

   bmpru_queue #(
      .DEPTH     (BMPRU_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (pop),
      .head_job  (head_job)
   );

   bmpru_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_not_empty),
      .job              (head_job),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_rgb565 (rsp_pixel_rgb565),
      .rsp_out_x        (rsp_out_x),
      .rsp_src_row      (rsp_src_row),
      .rsp_row_last     (rsp_row_last),
      .rsp_image_last   (rsp_image_last)
   );

endmodule

@@ sv/bmpru_front.sv @@
// Front end: registers, row and column tracking, classification into work words.
module bmpru_front
   import bmpru_pkg::*;
#(
   parameter int MAX_WIDTH         = BMPRU_MAX_WIDTH,
   parameter int MAX_HEIGHT        = BMPRU_MAX_HEIGHT,
   parameter int SCALE_WIDTH_LIMIT = BMPRU_SCALE_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,
   input  logic [7:0]  req_data_byte,
   input  logic        q_full,
   output logic        push,
   output job_type     push_job
);

   localparam logic [11:0] MaxW     = (MAX_WIDTH > 2047) ? 12'd2047 : 12'(MAX_WIDTH);
   localparam logic [11:0] MaxH     = (MAX_HEIGHT > 2047) ? 12'd2047 : 12'(MAX_HEIGHT);
   localparam logic [11:0] ScaleLim = 12'(SCALE_WIDTH_LIMIT);

   logic [1:0]  depth_ff;
   logic [10:0] width_ff, height_ff;
   logic        double_ff;
   logic [10:0] col_ff, col_in;
   logic [12:0] rbc_ff, rbc_in;
   logic [10:0] row_ff, row_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] held_ff, held_in;

   logic [10:0] w_eff, h_eff, avail, col_next;
   logic        dbl_eff, active, col_lt_w, accept, row_done;
   logic [15:0] bits_w;
   logic [16:0] bits_w_rnd;
   logic [13:0] line_len, rbc_inc;
   logic [3:0]  npix, cnt;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= DEPTH_24BPP;
         width_ff  <= 11'd1;
         height_ff <= 11'd1;
         double_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEPTH:  depth_ff  <= csr_wdata[1:0];
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_DOUBLE: double_ff <= csr_wdata[0];
            default:    ;
         endcase
      end
   end

   // Saturated dimensions and doubling
   always_comb begin
      if (width_ff == 11'd0)            w_eff = 11'd1;
      else if ({1'b0, width_ff} > MaxW) w_eff = MaxW[10:0];
      else                              w_eff = width_ff;
      if (height_ff == 11'd0)            h_eff = 11'd1;
      else if ({1'b0, height_ff} > MaxH) h_eff = MaxH[10:0];
      else                               h_eff = height_ff;
      dbl_eff = double_ff && ({1'b0, w_eff} <= ScaleLim);
   end

   // Row length in bytes, padded to 32 bits
   always_comb begin
      case (depth_ff)
         DEPTH_1BPP: bits_w = {5'd0, w_eff};
         DEPTH_4BPP: bits_w = {3'd0, w_eff, 2'd0};
         DEPTH_8BPP: bits_w = {2'd0, w_eff, 3'd0};
         default:    bits_w = {1'd0, w_eff, 4'd0} + {2'd0, w_eff, 3'd0};
      endcase
      bits_w_rnd = {1'b0, bits_w} + 17'd31;
      line_len   = {bits_w_rnd[16:5], 2'b00};
   end

   // Pixels carried by this byte, cut at the row width
   always_comb begin
      col_lt_w = col_ff < w_eff;
      avail    = col_lt_w ? (w_eff - col_ff) : 11'd0;
      case (depth_ff)
         DEPTH_1BPP: npix = 4'd8;
         DEPTH_4BPP: npix = 4'd2;
         DEPTH_8BPP: npix = 4'd1;
         default:    npix = (col_lt_w && phase_ff == 2'd2) ? 4'd1 : 4'd0;
      endcase
      cnt      = ({7'd0, npix} <= avail) ? npix : avail[3:0];
      col_next = col_ff + {7'd0, cnt};
      active   = row_ff < h_eff;
      rbc_inc  = {1'b0, rbc_ff} + 14'd1;
      row_done = rbc_inc >= line_len;
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Work word for the back end
   always_comb begin
      push_job.is_pal    = (req_kind == KIND_PALETTE);
      push_job.pal_index = req_palette_index;
      push_job.pal_color = req_palette_color;
      push_job.data      = (depth_ff == DEPTH_24BPP) ?
                           to565(req_data_byte, held_ff[15:8], held_ff[7:0]) :
                           {8'd0, req_data_byte};
      push_job.depth     = depth_ff;
      push_job.col       = col_ff;
      push_job.cnt       = cnt;
      push_job.row       = row_ff[9:0];
      push_job.dbl       = dbl_eff;
      push_job.row_end   = (col_next == w_eff);
      push_job.last_row  = (row_ff == h_eff - 11'd1);
      push = accept && ((req_kind == KIND_PALETTE) ||
                        (req_kind == KIND_PIXEL && active && cnt != 4'd0));
   end

   // Progress state update
   always_comb begin
      col_in   = col_ff;
      rbc_in   = rbc_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      held_in  = held_ff;
      if (accept) begin
         case (req_kind)
            KIND_START: begin
               col_in   = 11'd0;
               rbc_in   = 13'd0;
               row_in   = 11'd0;
               phase_in = 2'd0;
               held_in  = 16'd0;
            end
            KIND_PIXEL: begin
               if (active) begin
                  col_in = col_next;
                  if (depth_ff == DEPTH_24BPP && col_lt_w) begin
                     case (phase_ff)
                        2'd0: begin
                           held_in  = {8'd0, req_data_byte};
                           phase_in = 2'd1;
                        end
                        2'd1: begin
                           held_in  = {req_data_byte, held_ff[7:0]};
                           phase_in = 2'd2;
                        end
                        default: phase_in = 2'd0;
                     endcase
                  end
                  if (row_done) begin
                     rbc_in   = 13'd0;
                     col_in   = 11'd0;
                     phase_in = 2'd0;
                     row_in   = row_ff + 11'd1;
                  end else begin
                     rbc_in = rbc_inc[12:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 11'd0;
         rbc_ff   <= 13'd0;
         row_ff   <= 11'd0;
         phase_ff <= 2'd0;
         held_ff  <= 16'd0;
      end else begin
         col_ff   <= col_in;
         rbc_ff   <= rbc_in;
         row_ff   <= row_in;
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

endmodule

@@ sv/bmpru_queue.sv @@
// Short queue of work words between the front end and the back end.
`include "bmp_row_pixel_unpacker_unit_defines.svh"
module bmpru_queue
   import bmpru_pkg::*;
#(
   parameter int DEPTH = BMPRU_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    not_empty,
   input  logic    pop,
   output job_type head_job
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   job_type         slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_job;
   end

   `BMPRU_ASSERT(a_no_push_full, clock, reset, push, !full)
   `BMPRU_ASSERT(a_no_pop_empty, clock, reset, pop, not_empty)
   `BMPRU_ASSERT_NEXT(a_fill_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ sv/bmpru_back.sv @@
// Back end: palette store, pixel sequencer and output register.
`include "bmp_row_pixel_unpacker_unit_defines.svh"
module bmpru_back
   import bmpru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_rgb565,
   output logic [10:0] rsp_out_x,
   output logic [9:0]  rsp_src_row,
   output logic        rsp_row_last,
   output logic        rsp_image_last
);

   localparam int PalAw = $clog2(BMPRU_PALETTE_ENTRIES);

   logic [23:0] pal_mem [BMPRU_PALETTE_ENTRIES];
   logic [23:0] rd_ff;

   logic        cur_vld_ff;
   job_type     cur_ff;
   logic [2:0]  j_ff;
   logic        k_ff;

   logic        o_vld_ff, o_direct_ff, o_rl_ff, o_il_ff;
   logic [15:0] o_data_ff;
   logic [10:0] o_x_ff;
   logic [9:0]  o_row_ff;

   logic             advance, is_pix, emit, last_copy, last_pix, done, rl;
   logic [PalAw-1:0] rd_idx;
   logic [10:0]      column, out_x;
   logic [3:0]       j_inc;

   // Sequencer control
   always_comb begin
      advance   = !o_vld_ff || rsp_ready;
      is_pix    = cur_vld_ff && !cur_ff.is_pal;
      emit      = is_pix && advance;
      last_copy = !cur_ff.dbl || k_ff;
      j_inc     = {1'b0, j_ff} + 4'd1;
      last_pix  = (j_inc == cur_ff.cnt);
      done      = cur_vld_ff && (cur_ff.is_pal || (advance && last_copy && last_pix));
      pop       = job_valid && (!cur_vld_ff || done);
      rl        = cur_ff.row_end && last_pix && last_copy;
   end

   // Palette index and column of the current pixel
   always_comb begin
      case (cur_ff.depth)
         DEPTH_1BPP: rd_idx = PalAw'(cur_ff.data[3'd7 - j_ff]);
         DEPTH_4BPP: rd_idx = j_ff[0] ? PalAw'(cur_ff.data[3:0]) : PalAw'(cur_ff.data[7:4]);
         default:    rd_idx = cur_ff.data[PalAw-1:0];
      endcase
      column = cur_ff.col + {8'd0, j_ff};
      out_x  = cur_ff.dbl ? {column[9:0], k_ff} : column;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         j_ff       <= 3'd0;
         k_ff       <= 1'b0;
      end else if (pop) begin
         cur_vld_ff <= 1'b1;
         j_ff       <= 3'd0;
         k_ff       <= 1'b0;
      end else if (done) begin
         cur_vld_ff <= 1'b0;
      end else if (emit) begin
         if (cur_ff.dbl && !k_ff) begin
            k_ff <= 1'b1;
         end else begin
            k_ff <= 1'b0;
            j_ff <= j_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= job;
   end

   // Palette store: written in queue order, read registered
   always_ff @(posedge clock) begin
      if (cur_vld_ff && cur_ff.is_pal) pal_mem[cur_ff.pal_index] <= cur_ff.pal_color;
      if (emit) rd_ff <= pal_mem[rd_idx];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (advance) begin
         o_vld_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         o_direct_ff <= (cur_ff.depth == DEPTH_24BPP);
         o_data_ff   <= cur_ff.data;
         o_x_ff      <= out_x;
         o_row_ff    <= cur_ff.row;
         o_rl_ff     <= rl;
         o_il_ff     <= rl && cur_ff.last_row;
      end
   end

   assign rsp_valid        = o_vld_ff;
   assign rsp_pixel_rgb565 = o_direct_ff ? o_data_ff : to565(rd_ff[23:16], rd_ff[15:8], rd_ff[7:0]);
   assign rsp_out_x        = o_x_ff;
   assign rsp_src_row      = o_row_ff;
   assign rsp_row_last     = o_rl_ff;
   assign rsp_image_last   = o_il_ff;

   `BMPRU_ASSERT(a_image_row_last, clock, reset, rsp_valid && rsp_image_last, rsp_row_last)
   `BMPRU_ASSERT(a_j_in_range, clock, reset, is_pix, {1'b0, j_ff} < cur_ff.cnt)
   `BMPRU_ASSERT(a_copy_only_dbl, clock, reset, is_pix && !cur_ff.dbl, !k_ff)

endmodule

@@ sim/bmp_row_pixel_unpacker_checker.sv @@
// Watches the unpacker's channels, predicts every pixel and compares the results.
`timescale 1ns / 1ps
module bmp_row_pixel_unpacker_checker
   import bmpru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [10:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_color,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_pixel_rgb565,
   input  logic [10:0] rsp_out_x,
   input  logic [9:0]  rsp_src_row,
   input  logic        rsp_row_last,
   input  logic        rsp_image_last,
   output int          mismatches,
   output int          pixels_outstanding
);

   typedef struct packed {
      logic [15:0] rgb;
      logic [10:0] x;
      logic [9:0]  row;
      logic        row_last;
      logic        image_last;
   } pixel_type;

   // predictor copy of the block's state and registers
   logic [23:0] palette_copy [BMPRU_PALETTE_ENTRIES];
   int          col_cnt = 0;
   int          byte_cnt = 0;
   int          row_cnt = 0;
   int          channel_step = 0;
   logic [15:0] held_bg = '0;
   logic [1:0]  depth_reg = DEPTH_24BPP;
   int          width_reg = 1;
   int          height_reg = 1;
   bit          dbl_reg = 1'b0;

   pixel_type   pixels_due [$];
   pixel_type   want;
   int          errors = 0;

   function automatic logic [15:0] rgb565_of(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic logic [15:0] palette_pixel(input logic [7:0] idx);
      logic [23:0] c;
      c = palette_copy[idx];
      return rgb565_of(c[23:16], c[15:8], c[7:0]);
   endfunction

   function automatic int clamp_dim(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic flag_mismatch(input string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic clear_progress();
      col_cnt = 0;
      byte_cnt = 0;
      row_cnt = 0;
      channel_step = 0;
      held_bg = '0;
   endtask

   // one source pixel, sent once or twice; columns past the width are dropped
   task automatic push_pixel(input logic [15:0] rgb, input int w, input int h, input bit dbl);
      int copies;
      int k;
      pixel_type p;
      copies = dbl ? 2 : 1;
      if (col_cnt >= w) return;
      for (k = 0; k < copies; k++) begin
         p.rgb        = rgb;
         p.x          = 11'(col_cnt * copies + k);
         p.row        = 10'(row_cnt);
         p.row_last   = (col_cnt == w - 1) && (k == copies - 1);
         p.image_last = p.row_last && (row_cnt == h - 1);
         pixels_due.push_back(p);
      end
      col_cnt++;
   endtask

   // expected pixels for one accepted input word
   task automatic unpack_word(input logic [1:0] kind, input logic [7:0] idx,
                              input logic [23:0] color, input logic [7:0] data);
      int w;
      int h;
      int bits;
      int line;
      int i;
      bit dbl;
      if (kind == KIND_PALETTE) begin
         palette_copy[idx] = color;
         return;
      end
      if (kind == KIND_START) begin
         clear_progress();
         return;
      end
      if (kind != KIND_PIXEL) return;

      w = clamp_dim(width_reg, BMPRU_MAX_WIDTH);
      h = clamp_dim(height_reg, BMPRU_MAX_HEIGHT);
      // bytes past the last row are dropped
      if (row_cnt >= h) return;
      dbl = dbl_reg && (w <= BMPRU_SCALE_LIMIT);
      case (depth_reg)
         DEPTH_1BPP: bits = 1;
         DEPTH_4BPP: bits = 4;
         DEPTH_8BPP: bits = 8;
         default:    bits = 24;
      endcase
      line = ((bits * w + 31) / 32) * 4;

      case (depth_reg)
         DEPTH_1BPP: begin
            for (i = 7; i >= 0; i--) push_pixel(palette_pixel({7'd0, data[i]}), w, h, dbl);
         end
         DEPTH_4BPP: begin
            push_pixel(palette_pixel({4'd0, data[7:4]}), w, h, dbl);
            push_pixel(palette_pixel({4'd0, data[3:0]}), w, h, dbl);
         end
         DEPTH_8BPP: begin
            push_pixel(palette_pixel(data), w, h, dbl);
         end
         default: begin
            // blue, green, red; the pixel goes out on the red byte
            if (col_cnt < w) begin
               if (channel_step == 0) begin
                  held_bg = {8'd0, data};
                  channel_step = 1;
               end else if (channel_step == 1) begin
                  held_bg[15:8] = data;
                  channel_step = 2;
               end else begin
                  push_pixel(rgb565_of(data, held_bg[15:8], held_bg[7:0]), w, h, dbl);
                  channel_step = 0;
               end
            end
         end
      endcase

      // row ends on its padded length
      byte_cnt++;
      if (byte_cnt >= line) begin
         byte_cnt = 0;
         col_cnt = 0;
         channel_step = 0;
         row_cnt++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_progress();
         depth_reg = DEPTH_24BPP;
         width_reg = 1;
         height_reg = 1;
         dbl_reg = 1'b0;
         pixels_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_DEPTH:  depth_reg = csr_wdata[1:0];
               CSR_WIDTH:  width_reg = int'(csr_wdata);
               CSR_HEIGHT: height_reg = int'(csr_wdata);
               default:    dbl_reg = csr_wdata[0];
            endcase
         end
         if (req_valid && req_ready)
            unpack_word(req_kind, req_palette_index, req_palette_color, req_data_byte);
         // compare each accepted pixel word against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            if (pixels_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected pixel %h at x %0d row %0d",
                                       rsp_pixel_rgb565, rsp_out_x, rsp_src_row));
            end else begin
               want = pixels_due.pop_front();
               if (rsp_pixel_rgb565 !== want.rgb)
                  flag_mismatch($sformatf("pixel_rgb565 %h, want %h (x %0d row %0d)",
                                          rsp_pixel_rgb565, want.rgb, want.x, want.row));
               if (rsp_out_x !== want.x)
                  flag_mismatch($sformatf("out_x %0d, want %0d (row %0d)",
                                          rsp_out_x, want.x, want.row));
               if (rsp_src_row !== want.row)
                  flag_mismatch($sformatf("src_row %0d, want %0d (x %0d)",
                                          rsp_src_row, want.row, want.x));
               if (rsp_row_last !== want.row_last)
                  flag_mismatch($sformatf("row_last %b, want %b (x %0d row %0d)",
                                          rsp_row_last, want.row_last, want.x, want.row));
               if (rsp_image_last !== want.image_last)
                  flag_mismatch($sformatf("image_last %b, want %b (x %0d row %0d)",
                                          rsp_image_last, want.image_last, want.x, want.row));
            end
         end
      end
      mismatches <= errors;
      pixels_outstanding <= pixels_due.size();
   end

endmodule

@@ sim/testbench.sv @@
// Drives the bitmap row unpacker with palette and pixel words and gives the verdict.
`timescale 1ns / 1ps
module testbench;
   import bmpru_pkg::*;

   localparam int         CYCLE_LIMIT  = 1_500_000;
   localparam int         DRAIN_CYCLES = 32;
   localparam int         RANDOM_WORDS = 400;
   localparam logic [1:0] KIND_NOISE   = 2'd3;   // unused kind, block ignores it

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [10:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [7:0]  req_palette_index = '0;
   logic [23:0] req_palette_color = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_pixel_rgb565;
   logic [10:0] rsp_out_x;
   logic [9:0]  rsp_src_row;
   logic        rsp_row_last;
   logic        rsp_image_last;

   int mismatches;
   int pixels_outstanding;
   int cycle_count = 0;
   int stall_left = 0;
   int words_sent = 0;
   bit quiet = 1'b0;

   // image setup as last programmed
   logic [1:0] cur_depth = DEPTH_24BPP;
   int         cur_width = 1;
   int         cur_height = 1;

   bmp_row_pixel_unpacker_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_palette_index (req_palette_index),
      .req_palette_color (req_palette_color),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_rgb565  (rsp_pixel_rgb565),
      .rsp_out_x         (rsp_out_x),
      .rsp_src_row       (rsp_src_row),
      .rsp_row_last      (rsp_row_last),
      .rsp_image_last    (rsp_image_last)
   );

   bmp_row_pixel_unpacker_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_palette_index  (req_palette_index),
      .req_palette_color  (req_palette_color),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_rgb565   (rsp_pixel_rgb565),
      .rsp_out_x          (rsp_out_x),
      .rsp_src_row        (rsp_src_row),
      .rsp_row_last       (rsp_row_last),
      .rsp_image_last     (rsp_image_last),
      .mismatches         (mismatches),
      .pixels_outstanding (pixels_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic int clamp_dim(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // one input word; valid stays up across back-to-back words
   task automatic send_word(input logic [1:0] kind, input logic [7:0] idx,
                            input logic [23:0] color, input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_palette_index <= idx;
      req_palette_color <= color;
      req_data_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind != KIND_NOISE) words_sent++;
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_word(KIND_PIXEL, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                data);
   endtask

   task automatic send_start();
      send_word(KIND_START, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                8'($urandom_range(0, 255)));
   endtask

   // all pixels in, then let trailing no-result words clear the queue
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] depth, input int w, input int h, input bit dbl);
      logic [10:0] vals [0:3];
      int a;
      wait_drained();
      vals[CSR_DEPTH]  = {9'd0, depth};
      vals[CSR_WIDTH]  = 11'(w);
      vals[CSR_HEIGHT] = 11'(h);
      vals[CSR_DOUBLE] = {10'd0, dbl};
      for (a = 0; a < 4; a++) begin
         csr_we <= 1'b1;
         csr_addr <= 2'(a);
         csr_wdata <= vals[a];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cur_depth = depth;
      cur_width = w;
      cur_height = h;
   endtask

   initial begin
      int i, j, r, base, w, h, bits, line, rows, nbytes;
      logic [1:0] depth;
      int pick_w, pick_h;
      bit first_phase;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // load every palette entry, black and white at the ends
      for (i = 0; i < BMPRU_PALETTE_ENTRIES; i++)
         send_word(KIND_PALETTE, 8'(i),
                   (i == 0) ? 24'h000000 : (i == 255) ? 24'hFFFFFF
                                                      : 24'($urandom_range(0, 24'hFFFFFF)),
                   8'($urandom_range(0, 255)));

      // reset setup, 24 bpp 1 x 1: white pixel, byte past the end, unused kind
      send_start();
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h55);
      send_word(KIND_NOISE, 8'hFF, 24'hFFFFFF, 8'hFF);

      // 24 bpp single pixel doubled
      configure(DEPTH_24BPP, 1, 1, 1'b1);
      send_start();
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      send_byte(8'($urandom_range(0, 255)));

      // 1 bpp doubled, width 5 cuts the byte, height zero reads as one
      configure(DEPTH_1BPP, 5, 0, 1'b1);
      send_start();
      send_byte(8'hA5);
      repeat (3) send_byte(8'($urandom_range(0, 255)));

      // 4 bpp, the last nibble falls past the width
      configure(DEPTH_4BPP, 3, 1, 1'b0);
      send_start();
      send_byte(8'h0F);
      send_byte(8'hF0);
      repeat (2) send_byte(8'($urandom_range(0, 255)));

      // 8 bpp, lowest and highest index
      configure(DEPTH_8BPP, 2, 1, 1'b0);
      send_start();
      send_byte(8'h00);
      send_byte(8'hFF);
      repeat (2) send_byte(8'($urandom_range(0, 255)));

      // random images; the first one is the widest and tallest setting
      base = words_sent;
      first_phase = 1'b1;
      while (words_sent - base < RANDOM_WORDS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (first_phase) begin
            depth = DEPTH_1BPP;
            pick_w = 2047;
            pick_h = 2047;
         end else begin
            depth = 2'($urandom_range(0, 3));
            r = $urandom_range(0, 99);
            if (r < 70) pick_w = $urandom_range(1, 40);
            else if (r < 78)
               pick_w = (depth == DEPTH_1BPP || depth == DEPTH_4BPP) ?
                        $urandom_range(41, 128) : $urandom_range(1, 40);
            else if (r < 84) pick_w = 0;
            else if (r < 92) pick_w = $urandom_range(33, 34);
            else begin
               pick_w = $urandom_range(0, 1) ? 1024 : 2047;
               depth = DEPTH_1BPP;
            end
            r = $urandom_range(0, 99);
            if (r < 75) pick_h = $urandom_range(1, 4);
            else if (r < 85) pick_h = 0;
            else if (r < 92) pick_h = 1024;
            else pick_h = 2047;
         end
         configure(depth, pick_w, pick_h, 1'($urandom_range(0, 1)));

         // most images restart; the rest carry on under the new setup
         if (first_phase || $urandom_range(0, 6) != 0) send_start();
         repeat ($urandom_range(0, 3))
            send_word(KIND_PALETTE, 8'($urandom_range(0, 255)),
                      24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)));

         w = clamp_dim(cur_width, BMPRU_MAX_WIDTH);
         h = clamp_dim(cur_height, BMPRU_MAX_HEIGHT);
         case (cur_depth)
            DEPTH_1BPP: bits = 1;
            DEPTH_4BPP: bits = 4;
            DEPTH_8BPP: bits = 8;
            default:    bits = 24;
         endcase
         line = ((bits * w + 31) / 32) * 4;
         rows = $urandom_range(1, 3);
         if (rows > h) rows = h;
         if (line * rows > 160) rows = 1;
         nbytes = line * rows;
         // sometimes cut short, sometimes run past the end
         r = $urandom_range(0, 9);
         if (r == 0) nbytes = $urandom_range(1, nbytes);
         else if (r < 3) nbytes += $urandom_range(1, 6);

         for (j = 0; j < nbytes; j++) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               send_word(KIND_NOISE, 8'($urandom_range(0, 255)),
                         24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)));
            else if (r < 5)
               send_word(KIND_PALETTE, 8'($urandom_range(0, 255)),
                         24'($urandom_range(0, 24'hFFFFFF)), 8'($urandom_range(0, 255)));
            else if (r == 5)
               send_start();
            send_byte(8'($urandom_range(0, 255)));
         end
         first_phase = 1'b0;
      end

      quiet = 1'b0;
      wait_drained();
      if (mismatches == 0 && pixels_outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
